### src/assert_macros.svh
// Assertion helpers for the RTL files, included by the stencil module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/pgs_pkg.sv
`default_nettype none
package pgs_pkg;
    localparam int SAMPLE_W = 16;
    localparam int COORD_W = 8;
    localparam int RESULT_W = 48;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int DEFAULT_GRID_SIZE = 256;

    localparam logic [CFG_W-1:0] INV_SPACING_RST = 16'd2048;
    localparam logic [CFG_W-1:0] WAVENUMBER_SQ_RST = 16'd256;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_SPACING   = 1'b0,
        REG_WAVENUMBER_SQ = 1'b1
    } reg_idx_t;
endpackage
`default_nettype wire

### src/pgs_if.sv
`default_nettype none
interface pgs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [pgs_pkg::COORD_W-1:0]         col;
    logic [pgs_pkg::COORD_W-1:0]         row;
    logic signed [pgs_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, op, col, row, sample, input ready);
    modport sink (input valid, op, col, row, sample, output ready);
endinterface

interface pgs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pgs_pkg::RESULT_W-1:0] stress_value;
    logic                                saturated;

    modport source (output valid, stress_value, saturated, input ready);
    modport sink (input valid, stress_value, saturated, output ready);
endinterface
`default_nettype wire

### src/periodic_grid_stress_stencil.sv
`default_nettype none
// Channel    Direction  Beat contents
// in_ch      in         op, col, row, sample (write stores a sample, query asks for stress)
// out_ch     out        stress_value, saturated (one beat per query, none per write)
// cfg port   in         cfg_we, cfg_idx, cfg_wdata (inv_spacing, wavenumber_sq)
//
// A write beat goes through the coordinate wrap and then stores its sample; a query runs
// the coordinate wrap (none is needed for a grid of 256 or more), 11 grid reads through
// the one read port, then 11 multiplications on one 32x32 multiplier.
// The shared multiplier, which builds each product from four partial products, sets
// the query time. Reset clears the control state and loads the register defaults;
// the grid holds no reset value. A finished result waits in the output register while
// the next beat is taken; only the end of the following query stalls on it.
module periodic_grid_stress_stencil #(
    parameter int GRID_SIZE = pgs_pkg::DEFAULT_GRID_SIZE
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire [pgs_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire [pgs_pkg::CFG_W-1:0]       cfg_wdata,
    pgs_in_if.sink                         in_ch,
    pgs_out_if.source                      out_ch
);
    `include "assert_macros.svh"

    localparam int AW = $clog2(GRID_SIZE);
    localparam int CW = (AW > pgs_pkg::COORD_W) ? AW : pgs_pkg::COORD_W;
    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int MW = $clog2(DEPTH);
    localparam int ACC_W = 20;
    localparam int STG_W = 62;
    localparam logic signed [63:0] LIM = 64'sh0FFF_FFFF_FFFF_FFFF;
    localparam logic signed [STG_W-1:0] OUT_MAX = STG_W'(64'sh0000_7FFF_FFFF_FFFF);
    localparam logic signed [STG_W-1:0] OUT_MIN = -STG_W'(64'sh0000_8000_0000_0000);

    typedef enum logic [2:0] {S_IDLE, S_NORM, S_FETCH, S_LOAD, S_MUL, S_FIN} state_t;
    typedef enum logic [3:0] {
        CELL_CTR, CELL_PP, CELL_PM, CELL_ZM, CELL_ZP, CELL_MP,
        CELL_MM, CELL_ZPP, CELL_ZMM, CELL_MZ, CELL_PZ
    } cell_t;
    typedef enum logic [3:0] {
        STEP_H2, STEP_H3, STEP_G, STEP_F, STEP_X, STEP_P1,
        STEP_CY, STEP_CX, STEP_Y, STEP_Z, STEP_V
    } step_t;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
        return (x == AW'(GRID_SIZE - 1)) ? '0 : x + AW'(1);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] x);
        return (x == '0) ? AW'(GRID_SIZE - 1) : x - AW'(1);
    endfunction

    function automatic logic [MW-1:0] cell_addr(input logic [AW-1:0] x, input logic [AW-1:0] y);
        return MW'(y) * MW'(GRID_SIZE) + MW'(x);
    endfunction

    // Configuration registers.
    logic [pgs_pkg::CFG_W-1:0] inv_spacing_reg, wavenumber_sq_reg;

    // Control.
    state_t state_reg, state_next;
    cell_t  fetch_cnt_reg, acc_idx_reg;
    logic   acc_en_reg;
    step_t  step_reg;
    logic [1:0] pp_cnt_reg;
    logic   out_valid_reg;

    // Item registers.
    logic                                op_reg;
    logic [CW-1:0]                       col_reg, row_reg;
    logic signed [pgs_pkg::SAMPLE_W-1:0] sample_reg;

    // Grid memory.
    logic signed [pgs_pkg::SAMPLE_W-1:0] grid_mem [DEPTH];
    logic signed [pgs_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [MW-1:0] rd_addr, wr_addr;
    logic          wr_en;

    // Stencil sums and stage values.
    logic signed [ACC_W-1:0] s_acc_reg, ddy_reg, ddx_reg, de_reg;
    logic signed [pgs_pkg::SAMPLE_W-1:0] p_reg;
    logic signed [STG_W-1:0] h2_reg, h3_reg, g_reg, f_reg, x_reg, p1_reg;
    logic signed [STG_W-1:0] cy_reg, cx_reg, y_reg, z_reg;
    logic sat_reg;

    // Shared multiplier.
    logic [63:0]  ua_reg, ub_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic signed [63:0] a_op, b_op;
    logic [4:0]   sh_amt;
    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_shifted, rnd, shifted;
    logic         mag_over;
    logic [59:0]  mag;
    logic signed [STG_W-1:0] prod;

    logic signed [pgs_pkg::RESULT_W-1:0] out_value_reg;
    logic out_sat_reg;

    logic [AW-1:0] c, r, cp, cm, rp, rm, rpp, rmm;
    logic in_fire, out_fire, col_big, row_big, fin_last, out_load;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_fire     = out_valid_reg && out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.stress_value = out_value_reg;
    assign out_ch.saturated    = out_sat_reg;

    assign col_big = {1'b0, col_reg} >= (CW + 1)'(GRID_SIZE);
    assign row_big = {1'b0, row_reg} >= (CW + 1)'(GRID_SIZE);

    assign c   = col_reg[AW-1:0];
    assign r   = row_reg[AW-1:0];
    assign cp  = wrap_inc(c);
    assign cm  = wrap_dec(c);
    assign rp  = wrap_inc(r);
    assign rm  = wrap_dec(r);
    assign rpp = wrap_inc(rp);
    assign rmm = wrap_dec(rm);

    assign wr_addr = cell_addr(c, r);
    assign wr_en   = (state_reg == S_NORM) && !col_big && !row_big
                     && (op_reg == pgs_pkg::OP_WRITE);

    always_comb
    begin
        case (fetch_cnt_reg)
            CELL_CTR: rd_addr = cell_addr(c, r);
            CELL_PP:  rd_addr = cell_addr(cp, rp);
            CELL_PM:  rd_addr = cell_addr(cp, rm);
            CELL_ZM:  rd_addr = cell_addr(c, rm);
            CELL_ZP:  rd_addr = cell_addr(c, rp);
            CELL_MP:  rd_addr = cell_addr(cm, rp);
            CELL_MM:  rd_addr = cell_addr(cm, rm);
            CELL_ZPP: rd_addr = cell_addr(c, rpp);
            CELL_ZMM: rd_addr = cell_addr(c, rmm);
            CELL_MZ:  rd_addr = cell_addr(cm, r);
            CELL_PZ:  rd_addr = cell_addr(cp, r);
            default:  rd_addr = cell_addr(c, r);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[wr_addr] <= sample_reg;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

    // Operand selection and product scaling for each step of the sequence.
    always_comb
    begin
        case (step_reg)
            STEP_H2:
            begin
                a_op = 64'(inv_spacing_reg); b_op = 64'(inv_spacing_reg); sh_amt = 5'd0;
            end
            STEP_H3:
            begin
                a_op = 64'(h2_reg); b_op = 64'(inv_spacing_reg); sh_amt = 5'd0;
            end
            STEP_G:
            begin
                a_op = 64'(s_acc_reg); b_op = 64'(h3_reg); sh_amt = 5'd21;
            end
            STEP_F:
            begin
                a_op = 64'(de_reg); b_op = 64'(inv_spacing_reg); sh_amt = 5'd5;
            end
            STEP_X:
            begin
                a_op = 64'(wavenumber_sq_reg); b_op = 64'(f_reg); sh_amt = 5'd8;
            end
            STEP_P1:
            begin
                a_op = 64'(x_reg); b_op = 64'(f_reg); sh_amt = 5'd16;
            end
            STEP_CY:
            begin
                a_op = 64'(ddy_reg); b_op = 64'(h2_reg); sh_amt = 5'd12;
            end
            STEP_CX:
            begin
                a_op = 64'(ddx_reg); b_op = 64'(h2_reg); sh_amt = 5'd12;
            end
            STEP_Y:
            begin
                a_op = 64'(wavenumber_sq_reg); b_op = 64'(p_reg); sh_amt = 5'd4;
            end
            STEP_Z:
            begin
                a_op = 64'(y_reg); b_op = 64'(cy_reg); sh_amt = 5'd16;
            end
            STEP_V:
            begin
                a_op = 64'(wavenumber_sq_reg); b_op = 64'(z_reg); sh_amt = 5'd8;
            end
            default:
            begin
                a_op = '0; b_op = '0; sh_amt = 5'd0;
            end
        endcase
    end

    // One 32x32 partial product per cycle, placed at its weight.
    assign a_half = pp_cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign b_half = pp_cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
    assign pp     = 64'(a_half) * 64'(b_half);

    always_comb
    begin
        case (pp_cnt_reg)
            2'd0:    pp_shifted = 128'(pp);
            2'd3:    pp_shifted = {pp, 64'd0};
            default: pp_shifted = {32'd0, pp, 32'd0};
        endcase
    end

    // Round to nearest with ties away from zero on the magnitude, then clip.
    assign rnd      = (sh_amt == 5'd0) ? '0 : (128'd1 << (sh_amt - 5'd1));
    assign shifted  = (acc_reg + rnd) >> sh_amt;
    assign mag_over = |shifted[127:60];
    assign mag      = mag_over ? LIM[59:0] : shifted[59:0];
    assign prod     = neg_reg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});

    logic signed [63:0] sum_x, sum_y, sum_z;
    logic signed [STG_W-1:0] clip_x, clip_y, clip_z;
    logic over_x, over_y, over_z;

    assign sum_x = 64'(g_reg) + 64'(prod);
    assign sum_y = 64'(cx_reg) + 64'(cy_reg) + 64'(prod);
    assign sum_z = 64'(p1_reg) - 64'(prod);

    always_comb
    begin
        over_x = (sum_x > LIM) || (sum_x < -LIM);
        over_y = (sum_y > LIM) || (sum_y < -LIM);
        over_z = (sum_z > LIM) || (sum_z < -LIM);
        clip_x = (sum_x > LIM) ? STG_W'(LIM) : ((sum_x < -LIM) ? -STG_W'(LIM) : STG_W'(sum_x));
        clip_y = (sum_y > LIM) ? STG_W'(LIM) : ((sum_y < -LIM) ? -STG_W'(LIM) : STG_W'(sum_y));
        clip_z = (sum_z > LIM) ? STG_W'(LIM) : ((sum_z < -LIM) ? -STG_W'(LIM) : STG_W'(sum_z));
    end

    assign fin_last = (state_reg == S_FIN) && (step_reg == STEP_V);
    assign out_load = fin_last && !(out_valid_reg && !out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (!col_big && !row_big)
                begin
                    state_next = (op_reg == pgs_pkg::OP_WRITE) ? S_IDLE : S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (fetch_cnt_reg == CELL_PZ)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (pp_cnt_reg == 2'd3)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (step_reg != STEP_V)
                begin
                    state_next = S_LOAD;
                end
                else if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            fetch_cnt_reg     <= CELL_CTR;
            acc_idx_reg       <= CELL_CTR;
            acc_en_reg        <= 1'b0;
            step_reg          <= STEP_H2;
            pp_cnt_reg        <= 2'd0;
            out_valid_reg     <= 1'b0;
            inv_spacing_reg   <= pgs_pkg::INV_SPACING_RST;
            wavenumber_sq_reg <= pgs_pkg::WAVENUMBER_SQ_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    pgs_pkg::REG_INV_SPACING:   inv_spacing_reg <= cfg_wdata;
                    pgs_pkg::REG_WAVENUMBER_SQ: wavenumber_sq_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            acc_en_reg  <= (state_reg == S_FETCH);
            acc_idx_reg <= fetch_cnt_reg;
            if (state_reg == S_FETCH)
            begin
                fetch_cnt_reg <= cell_t'(fetch_cnt_reg + 4'd1);
            end
            else
            begin
                fetch_cnt_reg <= CELL_CTR;
            end
            if (state_reg == S_MUL)
            begin
                pp_cnt_reg <= pp_cnt_reg + 2'd1;
            end
            else
            begin
                pp_cnt_reg <= 2'd0;
            end
            if (in_fire)
            begin
                step_reg <= STEP_H2;
            end
            else if ((state_reg == S_FIN) && (step_reg != STEP_V))
            begin
                step_reg <= step_t'(step_reg + 4'd1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= in_ch.op;
            col_reg    <= CW'(in_ch.col);
            row_reg    <= CW'(in_ch.row);
            sample_reg <= in_ch.sample;
            s_acc_reg  <= '0;
            ddy_reg    <= '0;
            ddx_reg    <= '0;
            de_reg     <= '0;
            sat_reg    <= 1'b0;
        end
        if (state_reg == S_NORM)
        begin
            if (col_big)
            begin
                col_reg <= col_reg - CW'(GRID_SIZE);
            end
            if (row_big)
            begin
                row_reg <= row_reg - CW'(GRID_SIZE);
            end
        end

        // Each fetched cell adds its stencil weight to the sums that use it.
        if (acc_en_reg)
        begin
            case (acc_idx_reg)
                CELL_CTR:
                begin
                    p_reg   <= rd_data_reg;
                    ddy_reg <= ddy_reg - (ACC_W'(rd_data_reg) <<< 1);
                    ddx_reg <= ddx_reg - (ACC_W'(rd_data_reg) <<< 1);
                end
                CELL_ZM:
                begin
                    s_acc_reg <= s_acc_reg + (ACC_W'(rd_data_reg) <<< 2);
                    ddy_reg   <= ddy_reg + ACC_W'(rd_data_reg);
                    de_reg    <= de_reg - ACC_W'(rd_data_reg);
                end
                CELL_ZP:
                begin
                    s_acc_reg <= s_acc_reg - (ACC_W'(rd_data_reg) <<< 2);
                    ddy_reg   <= ddy_reg + ACC_W'(rd_data_reg);
                    de_reg    <= de_reg + ACC_W'(rd_data_reg);
                end
                CELL_PP, CELL_MP, CELL_ZPP:
                begin
                    s_acc_reg <= s_acc_reg + ACC_W'(rd_data_reg);
                end
                CELL_PM, CELL_MM, CELL_ZMM:
                begin
                    s_acc_reg <= s_acc_reg - ACC_W'(rd_data_reg);
                end
                CELL_MZ, CELL_PZ:
                begin
                    ddx_reg <= ddx_reg + ACC_W'(rd_data_reg);
                end
                default: ;
            endcase
        end

        if (state_reg == S_LOAD)
        begin
            neg_reg <= a_op[63] ^ b_op[63];
            ua_reg  <= a_op[63] ? 64'(-a_op) : 64'(a_op);
            ub_reg  <= b_op[63] ? 64'(-b_op) : 64'(b_op);
            acc_reg <= '0;
        end
        else if (state_reg == S_MUL)
        begin
            acc_reg <= acc_reg + pp_shifted;
        end

        // Finish a step: store the rounded product or fold it into a sum.
        if ((state_reg == S_FIN) && (step_reg != STEP_V))
        begin
            sat_reg <= sat_reg | mag_over
                       | ((step_reg == STEP_X) & over_x)
                       | ((step_reg == STEP_Y) & over_y)
                       | ((step_reg == STEP_Z) & over_z);
            case (step_reg)
                STEP_H2: h2_reg <= prod;
                STEP_H3: h3_reg <= prod;
                STEP_G:  g_reg  <= prod;
                STEP_F:  f_reg  <= prod;
                STEP_X:  x_reg  <= clip_x;
                STEP_P1: p1_reg <= prod;
                STEP_CY: cy_reg <= prod;
                STEP_CX: cx_reg <= prod;
                STEP_Y:  y_reg  <= clip_y;
                STEP_Z:  z_reg  <= clip_z;
                default: ;
            endcase
        end

        if (out_load)
        begin
            if (prod > OUT_MAX)
            begin
                out_value_reg <= pgs_pkg::RESULT_W'(OUT_MAX);
            end
            else if (prod < OUT_MIN)
            begin
                out_value_reg <= pgs_pkg::RESULT_W'(OUT_MIN);
            end
            else
            begin
                out_value_reg <= pgs_pkg::RESULT_W'(prod);
            end
            out_sat_reg <= sat_reg | mag_over | (prod > OUT_MAX) | (prod < OUT_MIN);
        end
    end

    // A result beat appears only at the end of the last multiplication.
    `ASSERT_IMPLIES(a_out_from_fin, clk, rst_n, $rose(out_valid_reg), $past(fin_last),
        "result raised outside the final step")
    // Stencil sums are only updated by the fetch pipeline.
    `ASSERT_IMPLIES(a_acc_in_fetch, clk, rst_n, acc_en_reg,
        (state_reg == S_FETCH) || (state_reg == S_LOAD), "stray stencil accumulate")
    // Memory writes happen only for write beats with a wrapped coordinate.
    `ASSERT_IMPLIES(a_write_clean, clk, rst_n, wr_en,
        (op_reg == pgs_pkg::OP_WRITE) && (state_reg == S_NORM), "stray grid write")
endmodule
`default_nettype wire
